// File: sv/dmsp_pkg.sv
// ----------------------------------------------------------------------------
// dmsp_pkg
// Shared types and constants for the decimal memory-size parser.
// ----------------------------------------------------------------------------
package dmsp_pkg;

  localparam int CNT_W  = 8;
  localparam int STAT_W = 2;
  localparam int CHAR_W = 8;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NODIGIT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_K  = 8'h4B;
  localparam logic [CHAR_W-1:0] CH_LO_K  = 8'h6B;
  localparam logic [CHAR_W-1:0] CH_UP_M  = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_LO_M  = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_UP_G  = 8'h47;
  localparam logic [CHAR_W-1:0] CH_LO_G  = 8'h67;
  localparam logic [CHAR_W-1:0] CH_UP_T  = 8'h54;
  localparam logic [CHAR_W-1:0] CH_LO_T  = 8'h74;

  localparam int SHIFT_K = 10;
  localparam int SHIFT_M = 20;
  localparam int SHIFT_G = 30;
  localparam int SHIFT_T = 40;

  // parser flags carried between the step logic and the state registers
  typedef struct packed {
    logic             active;
    logic             seen;
    logic [CNT_W-1:0] count;
  } dmsp_flags_t;

  // result side of one step
  typedef struct packed {
    logic              emit;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  consumed;
  } dmsp_res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] n);
    sat_inc = (n == {CNT_W{1'b1}}) ? n : n + 1'b1;
  endfunction

endpackage

// File: sv/dmsp_ifs.sv
// ----------------------------------------------------------------------------
// dmsp_in_if / dmsp_out_if
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
interface dmsp_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] character;

  modport source (output valid, output start_req, output character, input ready);
  modport sink   (input valid, input start_req, input character, output ready);
endinterface

interface dmsp_out_if #(parameter int VALUE_BITS = 64);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [1:0]            status;
  logic [7:0]            consumed;

  modport source (output valid, output value, output status, output consumed, input ready);
  modport sink   (input valid, input value, input status, input consumed, output ready);
endinterface

// File: sv/dmsp_step.sv
// ----------------------------------------------------------------------------
// dmsp_step
// One character of parsing: digit accumulate with overflow check, suffix
// shift, and token finish.
// ----------------------------------------------------------------------------
module dmsp_step import dmsp_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  start,
  input  logic [CHAR_W-1:0]     character,
  input  logic [VALUE_BITS-1:0] acc,
  input  dmsp_flags_t           flags,
  output logic [VALUE_BITS-1:0] acc_nxt,
  output dmsp_flags_t           flags_nxt,
  output dmsp_res_t             res,
  output logic [VALUE_BITS-1:0] value
);

  localparam logic [VALUE_BITS-1:0] VMAX  = {VALUE_BITS{1'b1}};
  localparam logic [VALUE_BITS-1:0] LIM_K = VMAX >> SHIFT_K;
  localparam logic [VALUE_BITS-1:0] LIM_M = VMAX >> SHIFT_M;
  localparam logic [VALUE_BITS-1:0] LIM_G = VMAX >> SHIFT_G;
  localparam logic [VALUE_BITS-1:0] LIM_T = VMAX >> SHIFT_T;

  logic [VALUE_BITS-1:0] a;
  logic [VALUE_BITS+3:0] wide;
  logic [VALUE_BITS-1:0] shifted;
  logic                  is_digit;
  logic                  is_sfx;
  logic                  fits;
  logic [3:0]            digit;
  logic [CHAR_W-1:0]     doff;

  assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
  assign doff     = character - CH_ZERO;
  assign digit    = doff[3:0];
  assign a        = start ? '0 : acc;
  // acc*10 + d; any bit above VALUE_BITS flags overflow
  assign wide     = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{VALUE_BITS{1'b0}}, digit};

  always_comb begin
    is_sfx  = 1'b1;
    fits    = 1'b0;
    shifted = a;
    case (character)
      CH_UP_K, CH_LO_K: begin
        fits    = (a <= LIM_K);
        shifted = a << SHIFT_K;
      end
      CH_UP_M, CH_LO_M: begin
        fits    = (a <= LIM_M);
        shifted = a << SHIFT_M;
      end
      CH_UP_G, CH_LO_G: begin
        fits    = (a <= LIM_G);
        shifted = a << SHIFT_G;
      end
      CH_UP_T, CH_LO_T: begin
        fits    = (a <= LIM_T);
        shifted = a << SHIFT_T;
      end
      default: is_sfx = 1'b0;
    endcase
  end

  always_comb begin
    acc_nxt   = a;
    flags_nxt = flags;
    if (start) begin
      flags_nxt.active = 1'b1;
      flags_nxt.seen   = 1'b0;
      flags_nxt.count  = '0;
    end
    res.emit     = 1'b0;
    res.status   = ST_OK;
    res.consumed = '0;
    value        = '0;
    if (flags_nxt.active) begin
      if (is_digit) begin
        if (wide[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
          res.emit         = 1'b1;
          res.status       = ST_OVERFLOW;
          flags_nxt.active = 1'b0;
        end else begin
          acc_nxt         = wide[VALUE_BITS-1:0];
          flags_nxt.seen  = 1'b1;
          flags_nxt.count = sat_inc(flags_nxt.count);
        end
      end else begin
        res.emit         = 1'b1;
        flags_nxt.active = 1'b0;
        if (!flags_nxt.seen) begin
          res.status = ST_NODIGIT;
        end else if (!is_sfx) begin
          value        = a;
          res.consumed = flags_nxt.count;
        end else if (fits) begin
          value        = shifted;
          res.consumed = sat_inc(flags_nxt.count);
        end else begin
          value        = a;
          res.status   = ST_OVERFLOW;
          res.consumed = sat_inc(flags_nxt.count);
        end
      end
    end
  end

endmodule

// File: sv/decimal_memory_size_parser.sv
// ----------------------------------------------------------------------------
// decimal_memory_size_parser
// ASCII decimal memory size (optional K/M/G/T suffix) to binary value.
// ----------------------------------------------------------------------------
// The character that ends the token goes from the input register through the
//   step logic into the result register, which then shows the result as valid.
// Throughput: one character per cycle while the output is not back-pressured;
//   set by the accumulate loop (multiply by ten plus add and compare) in the step logic.
// Reset clears the parser state and the valid flags of the input and result stages.
// ----------------------------------------------------------------------------
module decimal_memory_size_parser import dmsp_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  dmsp_in_if.sink      in_ch,
  dmsp_out_if.source   out_ch
);

  logic                  in_valid_r;
  logic                  in_start_r;
  logic [CHAR_W-1:0]     in_char_r;
  logic [VALUE_BITS-1:0] acc_r;
  logic [VALUE_BITS-1:0] acc_nxt;
  dmsp_flags_t           flags_r;
  dmsp_flags_t           flags_nxt;
  dmsp_res_t             res;
  logic [VALUE_BITS-1:0] step_value;
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [CNT_W-1:0]      out_count_r;
  logic                  fire;
  logic                  in_acc;

  assign fire         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || fire;
  assign in_acc       = in_ch.valid && in_ch.ready;

  dmsp_step #(.VALUE_BITS(VALUE_BITS)) u_step (
    .start     (in_start_r),
    .character (in_char_r),
    .acc       (acc_r),
    .flags     (flags_r),
    .acc_nxt   (acc_nxt),
    .flags_nxt (flags_nxt),
    .res       (res),
    .value     (step_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      flags_r     <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (fire) begin
        acc_r   <= acc_nxt;
        flags_r <= flags_nxt;
      end
      if (fire) begin
        out_valid_r <= res.emit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_start_r <= in_ch.start_req;
      in_char_r  <= in_ch.character;
    end
    if (fire && res.emit) begin
      out_value_r  <= step_value;
      out_status_r <= res.status;
      out_count_r  <= res.consumed;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.value    = out_value_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.consumed = out_count_r;

  a_nodigit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_NODIGIT) |-> (out_count_r == '0) && (out_value_r == '0))
    else $error("no-digit result with nonzero value or count");

  a_digit_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_OVERFLOW) && (out_count_r == '0) |-> (out_value_r == '0))
    else $error("digit overflow result with nonzero value");

  a_emit_ends_token: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.emit |=> !flags_r.active)
    else $error("token still active after a result");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.emit |=> out_valid_r)
    else $error("result lost on the way to the output register");

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the decimal memory-size parser. Characters go in
// over a valid/ready channel with random gaps and results come back under
// random back-pressure. An in-bench parser predicts every result, and each
// result word is checked field by field, in order. A directed set of tokens
// comes first. After it comes a long random mix of well-formed tokens,
// boundary values, suffixes, restarts and noise.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dmsp_pkg::*;

  localparam int VALUE_BITS = 64;
  localparam logic [VALUE_BITS-1:0] VAL_MAX = {VALUE_BITS{1'b1}};
  localparam int unsigned RANDOM_CHARS = 1500;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned HOLD_AFTER = 1000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam logic [CHAR_W-1:0] SUFFIX_CHARS [8] = '{
    CH_UP_K, CH_LO_K, CH_UP_M, CH_LO_M, CH_UP_G, CH_LO_G, CH_UP_T, CH_LO_T
  };

  typedef struct {
    bit               pause;
    logic             start;
    logic [CHAR_W-1:0] ch;
  } char_item_t;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic [STAT_W-1:0]     status;
    logic [CNT_W-1:0]      consumed;
  } size_result_t;

  logic clk;
  logic rst_n;

  dmsp_in_if in_if ();
  dmsp_out_if #(.VALUE_BITS(VALUE_BITS)) out_if ();

  decimal_memory_size_parser #(.VALUE_BITS(VALUE_BITS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  char_item_t   char_queue [$];
  size_result_t size_results_due [$];

  // parser state mirrored by the bench
  logic [VALUE_BITS-1:0] tok_acc;
  logic                  tok_active;
  logic                  tok_seen_digit;
  logic [CNT_W-1:0]      tok_len;

  int unsigned chars_accepted;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned n_ok, n_nodigit, n_overflow, n_suffix, n_saturated;
  int unsigned idle_cycles;
  int unsigned tx_gap, tx_steady;
  int unsigned rx_stall, rx_steady, rx_hold;
  bit          rx_hold_done;
  bit          tx_draining;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int unsigned idle_len(inout int unsigned steady);
    int unsigned r;
    if (steady > 0) begin
      steady--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      steady = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int unsigned suffix_shift(logic [CHAR_W-1:0] c);
    case (c)
      CH_UP_T, CH_LO_T: return SHIFT_T;
      CH_UP_G, CH_LO_G: return SHIFT_G;
      CH_UP_M, CH_LO_M: return SHIFT_M;
      CH_UP_K, CH_LO_K: return SHIFT_K;
      default: return 0;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] bump_len(logic [CNT_W-1:0] n);
    return (n == {CNT_W{1'b1}}) ? n : n + 1'b1;
  endfunction

  task automatic parse_char(input logic start, input logic [CHAR_W-1:0] ch);
    size_result_t r;
    logic [VALUE_BITS-1:0] d;
    int unsigned sh;
    bit done;
    done = 1'b0;
    if (start) begin
      tok_acc = '0;
      tok_seen_digit = 1'b0;
      tok_len = '0;
      tok_active = 1'b1;
    end
    if (!tok_active) return;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      d = VALUE_BITS'(ch - CH_ZERO);
      if (tok_acc > VAL_MAX / 10) begin
        r = '{'0, ST_OVERFLOW, '0};
        done = 1'b1;
      end else begin
        tok_acc = tok_acc * 10;
        if (tok_acc > VAL_MAX - d) begin
          r = '{'0, ST_OVERFLOW, '0};
          done = 1'b1;
        end else begin
          tok_acc = tok_acc + d;
          tok_seen_digit = 1'b1;
          tok_len = bump_len(tok_len);
        end
      end
    end else if (!tok_seen_digit) begin
      r = '{'0, ST_NODIGIT, '0};
      done = 1'b1;
    end else begin
      sh = suffix_shift(ch);
      if (sh == 0) r = '{tok_acc, ST_OK, tok_len};
      else if (tok_acc <= (VAL_MAX >> sh)) r = '{tok_acc << sh, ST_OK, bump_len(tok_len)};
      else r = '{tok_acc, ST_OVERFLOW, bump_len(tok_len)};
      if (sh != 0) n_suffix++;
      done = 1'b1;
    end
    if (done) begin
      tok_active = 1'b0;
      size_results_due.push_back(r);
    end
  endtask

  task automatic push_char(input logic st, input logic [CHAR_W-1:0] c);
    char_queue.push_back('{1'b0, st, c});
  endtask

  task automatic push_pause();
    char_queue.push_back('{1'b1, 1'b0, '0});
  endtask

  task automatic add_token(input string digits, input logic [CHAR_W-1:0] term,
                           input bit terminate = 1'b1);
    for (int i = 0; i < digits.len(); i++) push_char(i == 0, digits[i]);
    if (terminate) push_char(digits.len() == 0, term);
  endtask

  function automatic logic [CHAR_W-1:0] pick_term(bit want_suffix);
    logic [CHAR_W-1:0] c;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (want_suffix || r < 40) return SUFFIX_CHARS[$urandom_range(0, 7)];
    if (r < 60) return 8'h00;
    do c = CHAR_W'($urandom_range(0, 255)); while (c >= CH_ZERO && c <= CH_NINE);
    return c;
  endfunction

  task automatic rand_token(output int unsigned n_chars);
    int unsigned kind, ndig;
    bit force_suffix;
    logic [CHAR_W-1:0] c;
    n_chars = 0;
    force_suffix = 1'b0;
    kind = $urandom_range(0, 99);
    if (kind >= 92) begin
      repeat ($urandom_range(1, 4))
        push_char(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)));
      return;
    end
    if (kind < 55) ndig = $urandom_range(1, 8);
    else if (kind < 66) ndig = $urandom_range(18, 21);
    else if (kind < 80) begin
      ndig = $urandom_range(7, 14);
      force_suffix = 1'b1;
    end else if (kind < 91) ndig = 0;
    else ndig = $urandom_range(250, 270);
    for (int i = 0; i < ndig; i++) begin
      if (kind >= 91 && i + 3 < ndig) c = CH_ZERO;
      else if (kind >= 55 && kind < 66 && i == 0) c = CH_ZERO + 8'd1;
      else c = CH_ZERO + CHAR_W'($urandom_range(0, 9));
      push_char(i == 0, c);
    end
    n_chars = ndig;
    // now and then leave the token open so the next start drops it
    if (ndig == 0 || $urandom_range(0, 9) != 0) begin
      push_char(ndig == 0, pick_term(force_suffix));
      n_chars++;
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) push_char(1'b0, CHAR_W'($urandom_range(0, 255)));
  endtask

  // driver
  always @(posedge clk) begin
    char_item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.start_req <= 1'b0;
      in_if.character <= '0;
      tx_gap = 0;
      tx_steady = 0;
      tx_draining = 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (tx_gap > 0) begin
        in_if.valid <= 1'b0;
        tx_gap--;
      end else if (char_queue.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (char_queue[0].pause) begin
        in_if.valid <= 1'b0;
        if (tx_draining && size_results_due.size() == 0) begin
          void'(char_queue.pop_front());
          tx_draining = 1'b0;
        end else begin
          tx_draining = 1'b1;
        end
      end else begin
        nxt = char_queue.pop_front();
        in_if.valid <= 1'b1;
        in_if.start_req <= nxt.start;
        in_if.character <= nxt.ch;
        tx_gap = idle_len(tx_steady);
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_stall = 0;
      rx_steady = 0;
      rx_hold = 0;
      rx_hold_done = 1'b0;
    end else if (rx_hold > 0) begin
      out_if.ready <= 1'b0;
      rx_hold--;
    end else if (!rx_hold_done && chars_accepted >= HOLD_AFTER) begin
      out_if.ready <= 1'b0;
      rx_hold_done = 1'b1;
      rx_hold = LONG_HOLD;
    end else if (rx_stall > 0) begin
      out_if.ready <= 1'b0;
      rx_stall--;
    end else begin
      out_if.ready <= 1'b1;
      rx_stall = idle_len(rx_steady);
    end
  end

  // input side: predict on every accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      tok_acc = '0;
      tok_active = 1'b0;
      tok_seen_digit = 1'b0;
      tok_len = '0;
    end else if (in_if.valid && in_if.ready) begin
      chars_accepted++;
      parse_char(in_if.start_req, in_if.character);
    end
  end

  // output side: compare against the oldest prediction
  always @(posedge clk) begin
    size_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (size_results_due.size() == 0) begin
        $error("unexpected result: value %0d status %0d consumed %0d",
               out_if.value, out_if.status, out_if.consumed);
        mismatches++;
      end else begin
        want = size_results_due.pop_front();
        results_checked++;
        if (out_if.value !== want.value) begin
          $error("value mismatch: expected %0d, got %0d", want.value, out_if.value);
          mismatches++;
        end
        if (out_if.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_if.status);
          mismatches++;
        end
        if (out_if.consumed !== want.consumed) begin
          $error("consumed mismatch: expected %0d, got %0d", want.consumed, out_if.consumed);
          mismatches++;
        end
        case (want.status)
          ST_OK:       n_ok++;
          ST_NODIGIT:  n_nodigit++;
          ST_OVERFLOW: n_overflow++;
          default: ;
        endcase
        if (want.consumed == {CNT_W{1'b1}}) n_saturated++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    string zeros;
    int unsigned rand_total, n;
    bit paused_mid;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.start_req = 1'b0;
    in_if.character = '0;
    out_if.ready = 1'b0;
    chars_accepted = 0;
    results_checked = 0;
    mismatches = 0;
    n_ok = 0;
    n_nodigit = 0;
    n_overflow = 0;
    n_suffix = 0;
    n_saturated = 0;
    idle_cycles = 0;

    // ignored while no token is open
    push_char(1'b0, "A");
    push_char(1'b0, "5");
    push_char(1'b0, 8'hFF);
    add_token("0", 8'h00);
    add_token("18446744073709551615", 8'h00);
    add_token("18446744073709551616", " ");
    add_token("184467440737095516150", "x");
    push_char(1'b0, "7");
    add_token("1", CH_UP_K);
    add_token("3", CH_LO_K);
    add_token("5", CH_UP_M);
    add_token("7", CH_LO_M);
    add_token("9", CH_UP_G);
    add_token("4", CH_LO_G);
    add_token("6", CH_UP_T);
    add_token("8", CH_LO_T);
    add_token("16777215", CH_UP_T);
    add_token("16777216", CH_UP_T);
    add_token("17179869183", CH_LO_G);
    add_token("17179869184", CH_LO_G);
    add_token("", CH_UP_K);
    add_token("", 8'h00);
    add_token("123", 8'h00, 1'b0);
    add_token("45", 8'h2F);
    add_token("0099", 8'h3A);
    add_token("12", 8'hFF);
    zeros = "";
    repeat (300) zeros = {zeros, "0"};
    add_token({zeros, "7"}, CH_UP_M);
    push_pause();

    rand_total = 0;
    paused_mid = 1'b0;
    while (rand_total < RANDOM_CHARS) begin
      rand_token(n);
      rand_total += n;
      if (!paused_mid && rand_total >= 1400) begin
        push_pause();
        paused_mid = 1'b1;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (char_queue.size() != 0 || in_if.valid) @(posedge clk);
    while (size_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (size_results_due.size() != 0) begin
      $error("%0d expected results never arrived", size_results_due.size());
      mismatches++;
    end
    $display("%0d characters in, %0d results checked: %0d ok, %0d no digits, %0d overflow",
             chars_accepted, results_checked, n_ok, n_nodigit, n_overflow);
    $display("%0d tokens ended on a size suffix, %0d with a saturated count",
             n_suffix, n_saturated);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
